FILE: src/phwd_pkg.sv
`timescale 1ns / 1ps

package phwd_pkg;

    // default geometry and counter size
    localparam int ROWS_DEFAULT       = 336;
    localparam int COLS_DEFAULT       = 80;
    localparam int COUNT_BITS_DEFAULT = 16;

    // field widths
    localparam int WORD_W      = 32;
    localparam int ROW_W       = 9;
    localparam int COL_W       = 7;
    localparam int CODE_W      = 4;
    localparam int TIME_SLOT_W = 16;

    // header recognition
    localparam logic [WORD_W-1:0] HDR_WORD = 32'h00E9_0000;
    localparam logic [WORD_W-1:0] HDR_MASK = 32'hFFFF_0000;

    // record field positions
    localparam int COL_LSB   = 17;
    localparam int ROW_LSB   = 8;
    localparam int CODE1_LSB = 4;
    localparam int CODE2_LSB = 0;

    // codes at or above this carry no hit
    localparam logic [CODE_W-1:0] CODE_INVALID_MIN = 4'd14;

    typedef struct packed {
        logic [WORD_W-1:0] raw_word;
        logic              block_start;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]       pix_x;
        logic [COL_W-1:0]       pix_y;
        logic [CODE_W-1:0]      charge;
        logic [TIME_SLOT_W-1:0] time_slot;
        logic                   last;
    } out_item_t;

    // decoded hits of one word, packed to the front
    typedef struct packed {
        logic      first_vld;
        logic      second_vld;
        out_item_t first;
        out_item_t second;
    } hit_pair_t;

endpackage

FILE: src/phwd_core.sv
`timescale 1ns / 1ps

module phwd_core
    import phwd_pkg::*;
#(
    parameter int ROWS       = ROWS_DEFAULT,
    parameter int COLS       = COLS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  logic      fire,
    output hit_pair_t dec
);

    localparam int SW = (COUNT_BITS > TIME_SLOT_W) ? COUNT_BITS : TIME_SLOT_W;
    localparam logic [ROW_W-1:0] ROWS_V = ROW_W'(ROWS);
    localparam logic [COL_W-1:0] COLS_V = COL_W'(COLS);

    logic [COUNT_BITS-1:0] header_count_reg;
    logic [COUNT_BITS-1:0] header_count_next;
    logic                  halted_reg;
    logic                  halted_next;

    logic [COUNT_BITS-1:0] eff_count;
    logic                  eff_halted;
    logic                  is_header;
    logic                  is_record;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [CODE_W-1:0]     code1;
    logic [CODE_W-1:0]     code2;
    logic                  in_range;
    logic                  ok1;
    logic                  ok2;
    logic [SW-1:0]         slot_wide;
    out_item_t             hit1;
    out_item_t             hit2;

    always_comb
    begin
        eff_count  = item.block_start ? '0 : header_count_reg;
        eff_halted = item.block_start ? 1'b0 : halted_reg;
        is_header  = (item.raw_word & HDR_MASK) == HDR_WORD;
        is_record  = !eff_halted && !is_header && (eff_count != '0);

        header_count_next = eff_count;
        halted_next       = eff_halted;
        if (!eff_halted)
        begin
            if (is_header)
            begin
                if (!(&eff_count))
                    header_count_next = eff_count + 1'b1;
            end
            else if (eff_count == '0)
            begin
                halted_next = 1'b1;
            end
        end

        col   = item.raw_word[COL_LSB +: COL_W];
        row   = item.raw_word[ROW_LSB +: ROW_W];
        code1 = item.raw_word[CODE1_LSB +: CODE_W];
        code2 = item.raw_word[CODE2_LSB +: CODE_W];

        in_range = (col != '0) && (col <= COLS_V) && (row != '0) && (row <= ROWS_V);
        ok1 = is_record && in_range && (code1 < CODE_INVALID_MIN);
        // second hit sits on the next row, which must still be on the sensor
        ok2 = is_record && in_range && (code2 < CODE_INVALID_MIN) && (row < ROWS_V);

        slot_wide = SW'(eff_count) - 1'b1;

        hit1.pix_x     = ROWS_V - row;
        hit1.pix_y     = col - 1'b1;
        hit1.charge    = code1 + 1'b1;
        hit1.time_slot = slot_wide[TIME_SLOT_W-1:0];
        hit1.last      = !ok2;

        hit2.pix_x     = ROWS_V - row - 1'b1;
        hit2.pix_y     = col - 1'b1;
        hit2.charge    = code2 + 1'b1;
        hit2.time_slot = slot_wide[TIME_SLOT_W-1:0];
        hit2.last      = 1'b1;

        dec.first_vld  = ok1 || ok2;
        dec.second_vld = ok1 && ok2;
        dec.first      = ok1 ? hit1 : hit2;
        dec.second     = hit2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= '0;
            halted_reg       <= 1'b0;
        end
        else if (fire)
        begin
            header_count_reg <= header_count_next;
            halted_reg       <= halted_next;
        end
    end

endmodule

FILE: src/phwd_out.sv
`timescale 1ns / 1ps

module phwd_out
    import phwd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hit_pair_t dec,
    input  logic      load,
    output logic      pair_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      vld0_reg;
    logic      vld1_reg;
    out_item_t slot0_reg;
    out_item_t slot1_reg;
    logic      out_fire;

    assign out_fire   = vld0_reg && out_ready;
    // empty at the end of this cycle
    assign pair_ready = !vld0_reg || (out_fire && !vld1_reg);
    assign out_valid  = vld0_reg;
    assign out_data   = slot0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else if (load && pair_ready)
        begin
            vld0_reg <= dec.first_vld;
            vld1_reg <= dec.second_vld;
        end
        else if (out_fire)
        begin
            vld0_reg <= vld1_reg;
            vld1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pair_ready)
        begin
            slot0_reg <= dec.first;
            slot1_reg <= dec.second;
        end
        else if (out_fire)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

FILE: src/pixel_hit_word_decoder.sv
`timescale 1ns / 1ps

// channel   signals                         beat carries
// -------   -----------------------------   ------------------------------------
// in        in_valid, in_ready, in_data     one readout word and block start flag
// out       out_valid, out_ready, out_data  one decoded hit, last marks word end
//
// a word passes the input register and then the hit pair register before its first hit
// shows; the decode between them is one pass of logic
// one word per cycle while each word yields at most one hit and out_ready stays high; a
// two-hit word stalls input until the single hit pair register drains its hits one a beat
// reset clears the header counter, the halt flag and all valid bits
// in_ready falls only while the input register is full and the pair register cannot
// take its word in this cycle

module pixel_hit_word_decoder
    import phwd_pkg::*;
#(
    parameter int ROWS       = ROWS_DEFAULT,
    parameter int COLS       = COLS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // input register
    logic      in_valid_reg;
    in_item_t  in_data_reg;

    logic      pair_ready;
    logic      advance;
    hit_pair_t dec;

    // word leaves the input register when the pair register frees up
    assign advance  = in_valid_reg && pair_ready;
    assign in_ready = !in_valid_reg || pair_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // header counter, halt flag and record decode
    phwd_core #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_data_reg),
        .fire  (advance),
        .dec   (dec)
    );

    // hit pair register, drained one hit per beat
    phwd_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec        (dec),
        .load       (advance),
        .pair_ready (pair_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

`ifndef SYNTHESIS
    // hits are packed to the front
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && dec.second_vld |-> dec.first_vld)
        else $error("second hit without first hit");

    // a lone hit closes its word
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && dec.first_vld && !dec.second_vld |-> dec.first.last)
        else $error("single hit not marked last");

    // a hit that is not last is followed by its partner
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=> out_valid && out_data.last)
        else $error("second hit missing after non-last hit");

    // an accepted word always lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> in_valid_reg)
        else $error("accepted word lost");
`endif

endmodule
